FILE: rtl/bbr_pkg.sv
// bbr_pkg: shared types, register codes and constants of the rgba box blur
// depends on nothing
`default_nettype none

package bbr_pkg;

  // default sizes of the block
  localparam int MAX_KERNEL_DEF = 15;
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;

  // configuration register indexes
  localparam logic [1:0] CFG_KERNEL = 2'd0;
  localparam logic [1:0] CFG_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_HEIGHT = 2'd2;

  localparam logic [3:0]  KERNEL_RST = 4'd3;
  localparam logic [10:0] WIDTH_RST  = 11'd256;
  localparam logic [10:0] HEIGHT_RST = 11'd256;

  localparam int CH_W = 16;

  // ceil(2^32 / (k*k)) per kernel edge k
  localparam logic [63:0] RECIP_TBL [16] = '{
    64'd0,
    ((64'd1 << 32) + 64'd0)   / 64'd1,
    ((64'd1 << 32) + 64'd3)   / 64'd4,
    ((64'd1 << 32) + 64'd8)   / 64'd9,
    ((64'd1 << 32) + 64'd15)  / 64'd16,
    ((64'd1 << 32) + 64'd24)  / 64'd25,
    ((64'd1 << 32) + 64'd35)  / 64'd36,
    ((64'd1 << 32) + 64'd48)  / 64'd49,
    ((64'd1 << 32) + 64'd63)  / 64'd64,
    ((64'd1 << 32) + 64'd80)  / 64'd81,
    ((64'd1 << 32) + 64'd99)  / 64'd100,
    ((64'd1 << 32) + 64'd120) / 64'd121,
    ((64'd1 << 32) + 64'd143) / 64'd144,
    ((64'd1 << 32) + 64'd168) / 64'd169,
    ((64'd1 << 32) + 64'd195) / 64'd196,
    ((64'd1 << 32) + 64'd224) / 64'd225
  };

  typedef struct packed {
    logic [15:0] red_in;
    logic [15:0] green_in;
    logic [15:0] blue_in;
    logic [15:0] alpha_in;
    logic        is_flush;
  } bbr_in_t;

  typedef struct packed {
    logic [15:0] red_out;
    logic [15:0] green_out;
    logic [15:0] blue_out;
    logic [15:0] alpha_out;
    logic [9:0]  out_col;
    logic [9:0]  out_row;
    logic        frame_end;
  } bbr_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_DRAIN,
    ST_SHIFT,
    ST_SUM,
    ST_MUL,
    ST_OUT,
    ST_ADV
  } bbr_state_e;

endpackage

`default_nettype wire

FILE: rtl/bbr_ram.sv
// bbr_ram: generic single write port, single read port ram, registered read
// depends on nothing
`default_nettype none

module bbr_ram #(
  parameter int Width = 64,
  parameter int Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/bbr_cell.sv
// bbr_cell: one column slot of the horizontal window, shifts right and
// adds its column sum into the running window sum; uses bbr_pkg
`default_nettype none

module bbr_cell
  import bbr_pkg::*;
#(
  parameter int SW = 20,
  parameter int WS = 24,
  parameter int CW = 10,
  parameter int RW = 11
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   shift_i,
  input  wire logic                   valid_i,
  input  wire logic [3:0][SW-1:0]     colsum_i,
  input  wire logic [CW-1:0]          col_i,
  input  wire logic [RW-1:0]          row_i,
  input  wire logic [RW-1:0]          band_row_i,
  input  wire logic [CW+4:0]          ox_i,
  input  wire logic [CW+4:0]          hi_i,
  input  wire logic [3:0]             half_i,
  input  wire logic [3:0][WS-1:0]     psum_i,
  output logic                        valid_o,
  output logic      [3:0][SW-1:0]     colsum_o,
  output logic      [CW-1:0]          col_o,
  output logic      [RW-1:0]          row_o,
  output logic      [3:0][WS-1:0]     psum_o
);

  logic hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (shift_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      colsum_o <= colsum_i;
      col_o    <= col_i;
      row_o    <= row_i;
    end
  end

  // column belongs to the band and lies within ox-half .. ox+lagc
  assign hit = valid_o && (row_o == band_row_i) &&
               (((CW+5)'(col_o) + (CW+5)'(half_i)) >= ox_i) &&
               ((CW+5)'(col_o) <= hi_i);

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 4; c++) begin
      psum_o[c] <= psum_i[c] + (hit ? WS'(colsum_o[c]) : WS'(0));
    end
  end

endmodule

`default_nettype wire

FILE: rtl/box_blur_rgba.sv
// box_blur_rgba: top level of the streaming rgba box blur
// depends on bbr_pkg, bbr_ram, bbr_cell
//
// Pixels enter in raster order, one item at a time, and each item yields at
// most one blurred pixel, lagging by P rows and P columns (P = K-1-K/2).
// After a frame send P*width+P flush items to drain it. An item that yields
// a pixel goes through these steps before the next item is taken: its
// acceptance, K-1 reads of the line store (one read port) that build the
// column sum of the newest column, a wait for the last read data, one shift
// into the chain, the ripple of the window sum through the chain of column
// cells, one multiply by the reciprocal of K*K, the load of the output
// register and the advance of the position. An item that yields no pixel
// skips the multiply and the output load. For K of 1 there are no store
// reads and no wait for read data. A result still waiting at the output
// holds the next result back for as long as it waits. A write to an
// existing configuration register restarts the frame; items are refused in
// the cycle after any configuration write.
`default_nettype none

module box_blur_rgba
  import bbr_pkg::*;
#(
  parameter int MAX_KERNEL = MAX_KERNEL_DEF,
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire bbr_in_t     in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output bbr_out_t         out_data_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [10:0] cfg_data_i
);

  localparam int D  = MAX_KERNEL * (MAX_WIDTH + 1);
  localparam int AW = $clog2(D);
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int RW = $clog2(MAX_HEIGHT + MAX_KERNEL + 1);
  localparam int NW = $clog2(MAX_WIDTH * (MAX_HEIGHT + MAX_KERNEL) + 1);
  localparam int SW = $clog2(MAX_KERNEL * 65535 + 1);
  localparam int WS = $clog2(MAX_KERNEL * MAX_KERNEL * 65535 + 1);
  localparam int KC = $clog2(MAX_KERNEL + 1);

  // configuration
  logic [3:0]  kcfg_q;
  logic [10:0] wcfg_q, hcfg_q;
  logic        cfg_busy_q;
  logic        cfg_we;
  logic        cfg_hit;

  // effective sizes after clamping
  logic [3:0]    k, half, lagc;
  logic [WW-1:0] w;
  logic [HW-1:0] h;
  logic [NW-1:0] total_q, lag_q;

  // stream position
  logic [CW-1:0] c_q, oc_q;
  logic [RW-1:0] r_q, orow_q;
  logic [NW-1:0] n_q;
  logic [AW-1:0] a_q;

  // per item work
  bbr_state_e        state_q, state_d;
  logic              has_out_q, last_q;
  logic [3:0]        j_q;
  logic [AW-1:0]     ra_q;
  logic signed [RW:0] yy_q;
  logic              rdv_q;
  logic [3:0][SW-1:0] colacc_q;
  logic [KC-1:0]     cnt_q;
  logic [3:0][WS-1:0] quo_q;
  logic [63:0]       rdata;
  logic              yy_ok, rd_en, mem_we;
  logic [63:0]       wdata;
  logic              accept;

  // chain wiring
  logic                 e_v  [MAX_KERNEL+1];
  logic [3:0][SW-1:0]   e_cs [MAX_KERNEL+1];
  logic [CW-1:0]        e_col[MAX_KERNEL+1];
  logic [RW-1:0]        e_row[MAX_KERNEL+1];
  logic [3:0][WS-1:0]   e_ps [MAX_KERNEL+1];
  logic                 shift, clr;
  logic [RW-1:0]        band_row;
  logic [CW+4:0]        band_ox, band_hi;

  assign k = (kcfg_q == 4'd0) ? 4'd1 :
             ((int'(kcfg_q) > MAX_KERNEL) ? 4'(MAX_KERNEL) : kcfg_q);
  assign w = (wcfg_q == 11'd0) ? WW'(1) :
             ((int'(wcfg_q) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(wcfg_q));
  assign h = (hcfg_q == 11'd0) ? HW'(1) :
             ((int'(hcfg_q) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(hcfg_q));
  assign half = k >> 1;
  assign lagc = k - 4'd1 - half;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  // only a write to an existing register restarts the frame
  assign cfg_hit     = cfg_we && ((cfg_index_i == CFG_KERNEL) ||
                                  (cfg_index_i == CFG_WIDTH) ||
                                  (cfg_index_i == CFG_HEIGHT));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kcfg_q     <= KERNEL_RST;
      wcfg_q     <= WIDTH_RST;
      hcfg_q     <= HEIGHT_RST;
      cfg_busy_q <= 1'b0;
    end else begin
      cfg_busy_q <= cfg_we;
      if (cfg_we) begin
        case (cfg_index_i)
          CFG_KERNEL: kcfg_q <= cfg_data_i[3:0];
          CFG_WIDTH:  wcfg_q <= cfg_data_i;
          CFG_HEIGHT: hcfg_q <= cfg_data_i;
          default:    ;
        endcase
      end
    end
  end

  // frame size and output lag, registered from the clamped sizes
  always_ff @(posedge clk_i) begin
    total_q <= NW'(w) * NW'(h);
    lag_q   <= NW'(lagc) * NW'(w) + NW'(lagc);
  end

  assign in_ready_o = (state_q == ST_IDLE) && !cfg_busy_q;
  assign accept     = in_valid_i && in_ready_o;

  // the current pixel goes into the line store while inside the frame; flushes store zero
  assign mem_we = accept && (n_q < total_q);
  assign wdata  = in_data_i.is_flush ? 64'd0 :
                  {in_data_i.alpha_in, in_data_i.blue_in,
                   in_data_i.green_in, in_data_i.red_in};

  // older rows of the newest column, one per cycle, skipped outside the frame
  assign yy_ok = !yy_q[RW] && ($signed({1'b0, yy_q[RW-1:0]}) < $signed((RW+1)'(h)));
  assign rd_en = (state_q == ST_READ) && yy_ok;

  bbr_ram #(
    .Width(64),
    .Depth(D)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(a_q),
    .wdata_i(wdata),
    .re_i   (rd_en),
    .raddr_i(ra_q),
    .rdata_o(rdata)
  );

  function automatic logic [AW-1:0] row_back(input logic [AW-1:0] a,
                                             input logic [WW-1:0] wd);
    logic [AW:0] ax, wx;
    ax = {1'b0, a};
    wx = (AW+1)'(wd);
    if (ax >= wx) begin
      return AW'(ax - wx);
    end
    return AW'(ax + (AW+1)'(D) - wx);
  endfunction

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (accept) state_d = (k == 4'd1) ? ST_SHIFT : ST_READ;
      ST_READ:  if (j_q == k - 4'd1) state_d = ST_DRAIN;
      ST_DRAIN: state_d = ST_SHIFT;
      ST_SHIFT: state_d = ST_SUM;
      ST_SUM:   if (cnt_q == KC'(MAX_KERNEL - 1)) state_d = has_out_q ? ST_MUL : ST_ADV;
      ST_MUL:   state_d = ST_OUT;
      ST_OUT:   if (!out_valid_o || out_ready_i) state_d = ST_ADV;
      ST_ADV:   state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // item datapath
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rdv_q <= 1'b0;
    end else begin
      rdv_q <= rd_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      has_out_q <= (n_q >= lag_q) && ((n_q - lag_q) < total_q);
      last_q    <= (n_q - lag_q) == (total_q - NW'(1));
      j_q       <= 4'd1;
      ra_q      <= row_back(a_q, w);
      yy_q      <= $signed({1'b0, r_q}) - (RW+1)'(1);
      for (int c = 0; c < 4; c++) begin
        colacc_q[c] <= (n_q < total_q) ? SW'(wdata[CH_W*c +: CH_W]) : SW'(0);
      end
    end else begin
      if (state_q == ST_READ) begin
        j_q  <= j_q + 4'd1;
        ra_q <= row_back(ra_q, w);
        yy_q <= yy_q - (RW+1)'(1);
      end
      if (rdv_q) begin
        for (int c = 0; c < 4; c++) begin
          colacc_q[c] <= colacc_q[c] + SW'(rdata[CH_W*c +: CH_W]);
        end
      end
    end
    if (state_q == ST_SHIFT) begin
      cnt_q <= '0;
    end else if (state_q == ST_SUM) begin
      cnt_q <= cnt_q + KC'(1);
    end
    if (state_q == ST_MUL) begin
      for (int c = 0; c < 4; c++) begin
        quo_q[c] <= (k == 4'd1) ? e_ps[MAX_KERNEL][c] :
                    WS'((64'(e_ps[MAX_KERNEL][c]) * {32'd0, RECIP_TBL[k][31:0]}) >> 32);
      end
    end
  end

  // chain of column cells
  assign shift       = (state_q == ST_SHIFT);
  assign clr         = (n_q == '0);
  assign e_v[0]      = 1'b1;
  assign e_cs[0]     = colacc_q;
  assign e_col[0]    = c_q;
  assign e_row[0]    = r_q;
  assign e_ps[0]     = '0;
  assign band_row    = orow_q + RW'(lagc);
  assign band_ox     = (CW+5)'(oc_q);
  assign band_hi     = (CW+5)'(oc_q) + (CW+5)'(lagc);

  for (genvar i = 0; i < MAX_KERNEL; i++) begin : g_cell
    logic vin;
    // a new frame starts with an empty window
    assign vin = (i == 0) ? e_v[0] : (e_v[i] && !clr);
    bbr_cell #(
      .SW(SW),
      .WS(WS),
      .CW(CW),
      .RW(RW)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .shift_i   (shift),
      .valid_i   (vin),
      .colsum_i  (e_cs[i]),
      .col_i     (e_col[i]),
      .row_i     (e_row[i]),
      .band_row_i(band_row),
      .ox_i      (band_ox),
      .hi_i      (band_hi),
      .half_i    (half),
      .psum_i    (e_ps[i]),
      .valid_o   (e_v[i+1]),
      .colsum_o  (e_cs[i+1]),
      .col_o     (e_col[i+1]),
      .row_o     (e_row[i+1]),
      .psum_o    (e_ps[i+1])
    );
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (state_q == ST_OUT && (!out_valid_o || out_ready_i)) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_OUT && (!out_valid_o || out_ready_i)) begin
      out_data_o.red_out   <= quo_q[0][15:0];
      out_data_o.green_out <= quo_q[1][15:0];
      out_data_o.blue_out  <= quo_q[2][15:0];
      out_data_o.alpha_out <= quo_q[3][15:0];
      out_data_o.out_col   <= 10'(oc_q);
      out_data_o.out_row   <= 10'(orow_q);
      out_data_o.frame_end <= last_q;
    end
  end

  // stream position, restarted by a write to an existing register or after the last output
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_q    <= '0;
      r_q    <= '0;
      n_q    <= '0;
      a_q    <= '0;
      oc_q   <= '0;
      orow_q <= '0;
    end else if (cfg_hit || (state_q == ST_ADV && has_out_q && last_q)) begin
      c_q    <= '0;
      r_q    <= '0;
      n_q    <= '0;
      a_q    <= '0;
      oc_q   <= '0;
      orow_q <= '0;
    end else if (state_q == ST_ADV) begin
      n_q <= n_q + NW'(1);
      a_q <= (a_q == AW'(D - 1)) ? '0 : a_q + AW'(1);
      if (WW'(c_q) + WW'(1) == w) begin
        c_q <= '0;
        r_q <= r_q + RW'(1);
      end else begin
        c_q <= c_q + CW'(1);
      end
      if (has_out_q) begin
        if (WW'(oc_q) + WW'(1) == w) begin
          oc_q   <= '0;
          orow_q <= orow_q + RW'(1);
        end else begin
          oc_q <= oc_q + CW'(1);
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/bbr_checker.sv
// bbr_checker: port level checks of box_blur_rgba, bound to the top level
// depends on bbr_pkg
`default_nettype none

module bbr_checker
  import bbr_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire bbr_out_t    out_data_o,
  input wire logic        cfg_valid_i,
  input wire logic        cfg_ready_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // one item at a time
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("item taken while busy");

  // size registers settle before the next item
  a_cfg_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_o |=> !in_ready_o)
    else $error("item taken right after a write");

endmodule

bind box_blur_rgba bbr_checker u_bbr_checker (.*);

`default_nettype wire
